// ===== rtl/mbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types and constants of the MSB-first bit packer.
// ----------------------------------------------------------------------------
package mbp_pkg;

   // Command codes carried on the input channel.
   typedef enum logic [1:0] {
      CMD_RAW    = 2'd0,
      CMD_VARINT = 2'd1,
      CMD_EXPG   = 2'd2,
      CMD_FLUSH  = 2'd3
   } cmd_type;

   // Widths of the fields and of the internal code word.
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 6;
   localparam int BYTE_W     = 8;
   localparam int FILL_W     = 3;
   localparam int CODE_W     = 64;
   localparam int LEN_W      = 6;
   localparam int TOTAL_W    = 7;
   localparam int NBYTES_W   = 4;
   localparam int GROUP_W    = 7;
   localparam int RAW_MAX    = 32;

   // One classified item as it travels from the front to the back.
   // The code word is left-aligned: its first bit sits at the top.
   typedef struct packed {
      logic [CODE_W-1:0] word;
      logic [LEN_W-1:0]  len;
      logic              flush;
      logic              err;
   } mbp_entry_type;

   // One result item.
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              last;
      logic              error;
   } mbp_result_type;

endpackage

// ===== rtl/mbp_fifo.sv =====
// ----------------------------------------------------------------------------
// mbp_fifo
// Small flip-flop queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module mbp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr;
   logic             do_rd;

   // Status and the head item.
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   // Pointer wrap and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage; no reset needed.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/mbp_front.sv =====
// ----------------------------------------------------------------------------
// mbp_front
// Accepts commands and turns each into a left-aligned code word and length.
// ----------------------------------------------------------------------------
module mbp_front
   import mbp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [1:0]          req_cmd,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [COUNT_W-1:0]  req_bit_count,
   output logic                q_push,
   output mbp_entry_type       q_data,
   input  logic                q_full
);

   // Index of the highest set bit of a nonzero word.
   function automatic logic [4:0] msb_index(input logic [VALUE_W-1:0] v);
      logic [4:0] idx;
      idx = '0;
      for (int i = 0; i < VALUE_W; i++) begin
         if (v[i]) begin
            idx = 5'(i);
         end
      end
      return idx;
   endfunction

   // Stage A: captured input item.
   logic               a_valid_ff;
   cmd_type            a_cmd_ff;
   logic [VALUE_W-1:0] a_value_ff;
   logic [COUNT_W-1:0] a_count_ff;

   // Stage B: classified item, code still right-aligned unless b_left_ff.
   logic               b_valid_ff;
   logic [CODE_W-1:0]  b_word_ff, b_word_in;
   logic [LEN_W-1:0]   b_len_ff, b_len_in;
   logic               b_left_ff, b_left_in;
   logic               b_flush_ff, b_flush_in;
   logic               b_err_ff, b_err_in;

   logic ready_a;
   logic ready_b;

   logic [COUNT_W-1:0]     raw_n;
   logic [VALUE_W-1:0]     raw_code;
   logic [4:0][GROUP_W-1:0] grp;
   logic [3:0]             more;
   logic [4:0][BYTE_W-1:0] vbyte;
   logic [3:0]             vcount;
   logic [VALUE_W-1:0]     eg_v;
   logic [4:0]             eg_msb;
   logic [TOTAL_W-1:0]     b_shift;

   // Pipeline advance: each stage moves when the next one can take it.
   assign ready_b = !b_valid_ff || !q_full;
   assign ready_a = !a_valid_ff || ready_b;
   assign full    = !ready_a;

   // Raw bits: saturate the count and keep only the low bits.
   assign raw_n    = (a_count_ff > COUNT_W'(RAW_MAX)) ? COUNT_W'(RAW_MAX) : a_count_ff;
   assign raw_code = a_value_ff & ~({VALUE_W{1'b1}} << raw_n);

   // Varint: 7-bit groups, low group first, top bit flags more groups.
   always_comb begin
      grp[0] = a_value_ff[6:0];
      grp[1] = a_value_ff[13:7];
      grp[2] = a_value_ff[20:14];
      grp[3] = a_value_ff[27:21];
      grp[4] = {3'b000, a_value_ff[31:28]};
      more[0] = |a_value_ff[31:7];
      more[1] = |a_value_ff[31:14];
      more[2] = |a_value_ff[31:21];
      more[3] = |a_value_ff[31:28];
      for (int j = 0; j < 4; j++) begin
         vbyte[j] = {more[j], grp[j]};
      end
      vbyte[4] = {1'b0, grp[4]};
      if (more[3]) begin
         vcount = 4'd5;
      end else if (more[2]) begin
         vcount = 4'd4;
      end else if (more[1]) begin
         vcount = 4'd3;
      end else if (more[0]) begin
         vcount = 4'd2;
      end else begin
         vcount = 4'd1;
      end
   end

   // Exp-Golomb: value plus one, with one zero fewer than its bit count.
   assign eg_v   = a_value_ff + 1'b1;
   assign eg_msb = msb_index(eg_v);

   // Classification of the captured item.
   always_comb begin
      b_word_in  = '0;
      b_len_in   = '0;
      b_left_in  = 1'b0;
      b_flush_in = 1'b0;
      b_err_in   = 1'b0;
      unique case (a_cmd_ff)
         CMD_RAW: begin
            b_word_in = {{(CODE_W - VALUE_W){1'b0}}, raw_code};
            b_len_in  = raw_n;
         end
         CMD_VARINT: begin
            b_word_in = {vbyte[0], vbyte[1], vbyte[2], vbyte[3], vbyte[4],
                         {(CODE_W - 5 * BYTE_W){1'b0}}};
            b_len_in  = LEN_W'({vcount, 3'b000});
            b_left_in = 1'b1;
         end
         CMD_EXPG: begin
            if (a_value_ff == {VALUE_W{1'b1}}) begin
               b_err_in = 1'b1;
            end else begin
               b_word_in = {{(CODE_W - VALUE_W){1'b0}}, eg_v};
               b_len_in  = {eg_msb, 1'b1};
            end
         end
         CMD_FLUSH: begin
            b_flush_in = 1'b1;
         end
         default: begin
            b_flush_in = 1'b0;
         end
      endcase
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            a_valid_ff <= push;
         end
         if (ready_b) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && push) begin
         a_cmd_ff   <= cmd_type'(req_cmd);
         a_value_ff <= req_value;
         a_count_ff <= req_bit_count;
      end
      if (ready_b && a_valid_ff) begin
         b_word_ff  <= b_word_in;
         b_len_ff   <= b_len_in;
         b_left_ff  <= b_left_in;
         b_flush_ff <= b_flush_in;
         b_err_ff   <= b_err_in;
      end
   end

   // Left-align right-aligned codes on their way into the queue.
   assign b_shift = TOTAL_W'(CODE_W) - {1'b0, b_len_ff};

   always_comb begin
      q_data.word  = b_left_ff ? b_word_ff : (b_word_ff << b_shift);
      q_data.len   = b_len_ff;
      q_data.flush = b_flush_ff;
      q_data.err   = b_err_ff;
   end

   assign q_push = b_valid_ff && !q_full;

endmodule

// ===== rtl/mbp_back.sv =====
// ----------------------------------------------------------------------------
// mbp_back
// Merges code words into the partial byte and emits completed bytes.
// ----------------------------------------------------------------------------
module mbp_back
   import mbp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_empty,
   input  mbp_entry_type  q_data,
   output logic           q_pop,
   input  logic           res_full,
   output logic           res_push,
   output mbp_result_type res_data
);

   localparam int ACC_W = CODE_W + BYTE_W;

   // Bit stream state.
   logic [BYTE_W-1:0]   partial_ff, partial_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;

   // Bytes of the current item still to go out.
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [2:0]          left_ff, left_in;
   logic [FILL_W-1:0]   pend_fill_ff, pend_fill_in;

   logic                busy;
   logic [LEN_W-1:0]    eff_len;
   logic [TOTAL_W-1:0]  total;
   logic [NBYTES_W-1:0] nbytes;
   logic [ACC_W-1:0]    acc;

   assign busy = (left_ff != '0);

   // A flush pads the partial byte with zeros up to the byte boundary.
   always_comb begin
      if (q_data.flush) begin
         eff_len = (fill_ff == '0) ? '0 : LEN_W'(4'd8 - {1'b0, fill_ff});
      end else begin
         eff_len = q_data.len;
      end
   end

   // Append the code after the bits already held.
   assign total  = TOTAL_W'(fill_ff) + TOTAL_W'(eff_len);
   assign nbytes = total[TOTAL_W-1:3];
   assign acc    = {partial_ff, {CODE_W{1'b0}}} | ({q_data.word, {BYTE_W{1'b0}}} >> fill_ff);

   // Emission: first result on the cycle an item is taken, then one a cycle while the result queue has room.
   always_comb begin
      q_pop        = 1'b0;
      res_push     = 1'b0;
      res_data     = '0;
      partial_in   = partial_ff;
      fill_in      = fill_ff;
      acc_in       = acc_ff;
      left_in      = left_ff;
      pend_fill_in = pend_fill_ff;
      if (busy) begin
         if (!res_full) begin
            res_push            = 1'b1;
            res_data.out_byte   = acc_ff[ACC_W-1 -: BYTE_W];
            res_data.byte_valid = 1'b1;
            res_data.last       = (left_ff == 3'd1);
            acc_in              = acc_ff << BYTE_W;
            left_in             = left_ff - 1'b1;
            if (left_ff == 3'd1) begin
               partial_in = acc_ff[ACC_W-BYTE_W-1 -: BYTE_W];
               fill_in    = pend_fill_ff;
            end
         end
      end else if (!q_empty && !res_full) begin
         q_pop    = 1'b1;
         res_push = 1'b1;
         if (nbytes == '0) begin
            // Nothing completed: an empty result, flagged on a rejected code.
            res_data.last  = 1'b1;
            res_data.error = q_data.err;
            partial_in     = acc[ACC_W-1 -: BYTE_W];
            fill_in        = total[FILL_W-1:0];
         end else begin
            res_data.out_byte   = acc[ACC_W-1 -: BYTE_W];
            res_data.byte_valid = 1'b1;
            res_data.last       = (nbytes == 4'd1);
            if (nbytes == 4'd1) begin
               partial_in = acc[ACC_W-BYTE_W-1 -: BYTE_W];
               fill_in    = total[FILL_W-1:0];
            end else begin
               acc_in       = acc << BYTE_W;
               left_in      = 3'(nbytes - 4'd1);
               pend_fill_in = total[FILL_W-1:0];
            end
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         fill_ff    <= '0;
         left_ff    <= '0;
      end else begin
         partial_ff <= partial_in;
         fill_ff    <= fill_in;
         left_ff    <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      pend_fill_ff <= pend_fill_in;
   end

endmodule

// ===== rtl/msb_first_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// msb_first_bit_packer_unit
// Packs raw, varint and Exp-Golomb codes MSB first into a byte stream.
// ----------------------------------------------------------------------------
//  Channel   Handshake        Payload
//  input     push / full      req_cmd, req_value, req_bit_count
//  result    empty / pop      rsp_out_byte, rsp_byte_valid, rsp_last, rsp_error
//
// An item passes through front stages A and B before it enters the queue.
// The back gives one result a cycle while the result queue has room, so an
// item that completes k bytes (at most eight) holds the back until its bytes
// are out; items that give one result each flow at one a cycle.
// Reset is synchronous and empties both queues and the partial byte.
// A full result queue stalls the back; a full item queue stalls the front,
// which raises full once both of its stages hold an item.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_unit
   import mbp_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 4,
   parameter int RESULT_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_cmd,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [COUNT_W-1:0] req_bit_count,
   output logic               empty,
   input  logic               pop,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_byte_valid,
   output logic               rsp_last,
   output logic               rsp_error
);

   logic           q_push;
   logic           q_full;
   logic           q_pop;
   logic           q_empty;
   mbp_entry_type  q_wr_data;
   mbp_entry_type  q_rd_data;
   logic           res_push;
   logic           res_full;
   mbp_result_type res_wr_data;
   mbp_result_type res_rd_data;

   // Front: accept and classify.
   mbp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_cmd       (req_cmd),
      .req_value     (req_value),
      .req_bit_count (req_bit_count),
      .q_push        (q_push),
      .q_data        (q_wr_data),
      .q_full        (q_full)
   );

   // Queue of classified items between front and back.
   mbp_fifo #(
      .WIDTH ($bits(mbp_entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   // Back: bit merge and byte emission.
   mbp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_rd_data),
      .q_pop    (q_pop),
      .res_full (res_full),
      .res_push (res_push),
      .res_data (res_wr_data)
   );

   // Result queue facing the output port.
   mbp_fifo #(
      .WIDTH ($bits(mbp_result_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res_wr_data),
      .full    (res_full),
      .rd_en   (pop),
      .rd_data (res_rd_data),
      .empty   (empty)
   );

   assign rsp_out_byte   = res_rd_data.out_byte;
   assign rsp_byte_valid = res_rd_data.byte_valid;
   assign rsp_last       = res_rd_data.last;
   assign rsp_error      = res_rd_data.error;

   // The back only takes an item that the queue actually holds.
   a_pop_not_empty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("item queue popped while empty");

   // The back never writes a result into a full result queue.
   a_push_not_full : assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result written into full result queue");

   // A rejected code yields only an empty, final result.
   a_error_empty : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_error) |-> (rsp_last && !rsp_byte_valid))
      else $error("error result carries a byte or is not last");

   // Reset leaves no result waiting.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> empty)
      else $error("result waiting after reset");

endmodule
